FILE: rtl/fixed_block_pool_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Pool allocator assertion macros
// Concurrent assertion wrappers; they expand to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check a condition at every edge outside reset
`define FBPA_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("fbpa assertion failed");
// check that a condition implies another one on the next edge
`define FBPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbpa assertion failed");
`else
`define FBPA_ASSERT(lbl, clk, rst_n, expr)
`define FBPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pool allocator package
// Widths, codes and shared types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int IDX_W  = 10;
  localparam int CFG_W  = 17;
  localparam int REQ_W  = 17;
  localparam int OFF_W  = 26;
  localparam int STAT_W = 2;

  localparam int unsigned MAX_CHUNKS          = 1 << IDX_W;
  localparam int unsigned POOL_CHUNKS_DEFAULT = 1024;

  localparam logic [CFG_W-1:0] CHUNK_BYTES_RESET = 17'd64;
  localparam logic [CFG_W-1:0] MIN_CHUNK_BYTES   = 17'd8;
  localparam logic [CFG_W-1:0] MAX_CHUNK_BYTES   = 17'd65536;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_TOO_LARGE = 2'd2,
    STAT_IGNORED   = 2'd3
  } fbpa_status_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_POP
  } fbpa_state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } fbpa_mem_req_t;

endpackage

FILE: rtl/fbpa_next_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-chunk table
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_unit_defines.svh"

module fbpa_next_mem #(
  parameter int unsigned DEPTH = fbpa_pkg::POOL_CHUNKS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fbpa_pkg::fbpa_mem_req_t    mem_req,
  output logic [fbpa_pkg::IDX_W-1:0] mem_rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [fbpa_pkg::IDX_W-1:0] next_free_mem [DEPTH];
  logic [fbpa_pkg::IDX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      next_free_mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rdata_r <= next_free_mem[mem_req.raddr[AW-1:0]];
    end
  end

  assign mem_rdata = rdata_r;

  `FBPA_ASSERT(a_waddr_range, clk, rst_n, !mem_req.we || (32'(mem_req.waddr) < DEPTH))
  `FBPA_ASSERT(a_raddr_range, clk, rst_n, !mem_req.re || (32'(mem_req.raddr) < DEPTH))

endmodule

FILE: rtl/fbpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pool allocator controller
// Free-list head/tail/empty state, table init sweep, command decode, result register.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_unit_defines.svh"

module fbpa_ctrl #(
  parameter int unsigned POOL_CHUNKS = fbpa_pkg::POOL_CHUNKS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [fbpa_pkg::REQ_W-1:0]  in_request_bytes,
  input  logic                        in_pointer_valid,
  input  logic [fbpa_pkg::IDX_W-1:0]  in_free_index,
  input  logic [fbpa_pkg::CFG_W-1:0]  chunk_size,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fbpa_pkg::STAT_W-1:0] out_status,
  output logic [fbpa_pkg::IDX_W-1:0]  out_chunk_index,
  output logic [fbpa_pkg::OFF_W-1:0]  out_byte_offset,
  output fbpa_pkg::fbpa_mem_req_t     mem_req,
  input  logic [fbpa_pkg::IDX_W-1:0]  mem_rdata
);

  localparam int unsigned MEM_DEPTH =
    (POOL_CHUNKS < fbpa_pkg::MAX_CHUNKS) ? POOL_CHUNKS : fbpa_pkg::MAX_CHUNKS;
  localparam int PROD_W = fbpa_pkg::IDX_W + fbpa_pkg::CFG_W;

  fbpa_pkg::fbpa_state_t state_r, state_nxt;

  logic [fbpa_pkg::IDX_W-1:0]  sweep_r, sweep_nxt;
  logic [fbpa_pkg::IDX_W-1:0]  head_r, head_nxt;
  logic [fbpa_pkg::IDX_W-1:0]  tail_r, tail_nxt;
  logic                        empty_r, empty_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [fbpa_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [fbpa_pkg::IDX_W-1:0]  out_chunk_index_r, out_chunk_index_nxt;
  logic [fbpa_pkg::OFF_W-1:0]  out_byte_offset_r, out_byte_offset_nxt;

  logic              accept;
  logic              sweep_last;
  logic              too_large;
  logic              free_ok;
  logic              alloc_ok;
  logic              pop_link;
  logic [PROD_W-1:0] offset_prod;

  assign sweep_last  = (32'(sweep_r) == MEM_DEPTH - 1);
  assign accept      = in_valid && !in_stall;
  assign too_large   = (in_request_bytes > chunk_size);
  assign free_ok     = in_pointer_valid && (32'(in_free_index) < POOL_CHUNKS);
  assign alloc_ok    = (in_command == fbpa_pkg::CMD_ALLOC) && !empty_r && !too_large;
  assign pop_link    = alloc_ok && (head_r != tail_r);
  assign offset_prod = PROD_W'(head_r) * PROD_W'(chunk_size);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbpa_pkg::ST_INIT: if (sweep_last) state_nxt = fbpa_pkg::ST_IDLE;
      fbpa_pkg::ST_IDLE: if (accept && pop_link) state_nxt = fbpa_pkg::ST_POP;
      fbpa_pkg::ST_POP:  state_nxt = fbpa_pkg::ST_IDLE;
      default: state_nxt = fbpa_pkg::ST_INIT;
    endcase
  end

  // handshake and table port
  always_comb begin
    in_stall = 1'b1;
    mem_req  = '0;
    unique case (state_r)
      fbpa_pkg::ST_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep_r;
        mem_req.wdata = (32'(sweep_r) == POOL_CHUNKS - 1) ? '0 : sweep_r + 1'b1;
      end
      fbpa_pkg::ST_IDLE: begin
        in_stall = out_valid_r && out_stall;
        if (accept && pop_link) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = head_r;
        end
        // link the old tail to the returned chunk
        if (accept && (in_command == fbpa_pkg::CMD_FREE) && free_ok && !empty_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = tail_r;
          mem_req.wdata = in_free_index;
        end
      end
      fbpa_pkg::ST_POP: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // list state and result register
  always_comb begin
    sweep_nxt           = sweep_r;
    head_nxt            = head_r;
    tail_nxt            = tail_r;
    empty_nxt           = empty_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_status_nxt      = out_status_r;
    out_chunk_index_nxt = out_chunk_index_r;
    out_byte_offset_nxt = out_byte_offset_r;

    if (state_r == fbpa_pkg::ST_INIT) begin
      sweep_nxt = sweep_r + 1'b1;
    end

    if (state_r == fbpa_pkg::ST_POP) begin
      head_nxt = mem_rdata;
    end

    if (accept) begin
      out_valid_nxt       = 1'b1;
      out_status_nxt      = fbpa_pkg::STAT_DONE;
      out_chunk_index_nxt = '0;
      out_byte_offset_nxt = '0;
      if (in_command == fbpa_pkg::CMD_ALLOC) begin
        if (empty_r) begin
          out_status_nxt = fbpa_pkg::STAT_EXHAUSTED;
        end else if (too_large) begin
          out_status_nxt = fbpa_pkg::STAT_TOO_LARGE;
        end else begin
          out_chunk_index_nxt = head_r;
          out_byte_offset_nxt = offset_prod[fbpa_pkg::OFF_W-1:0];
          // last chunk: keep head and tail, mark empty
          if (head_r == tail_r) begin
            empty_nxt = 1'b1;
          end
        end
      end else begin
        if (!free_ok) begin
          out_status_nxt = fbpa_pkg::STAT_IGNORED;
        end else if (empty_r) begin
          head_nxt  = in_free_index;
          tail_nxt  = in_free_index;
          empty_nxt = 1'b0;
        end else begin
          tail_nxt = in_free_index;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbpa_pkg::ST_INIT;
      sweep_r     <= '0;
      head_r      <= '0;
      tail_r      <= fbpa_pkg::IDX_W'(POOL_CHUNKS - 1);
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r      <= out_status_nxt;
    out_chunk_index_r <= out_chunk_index_nxt;
    out_byte_offset_r <= out_byte_offset_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_chunk_index = out_chunk_index_r;
  assign out_byte_offset = out_byte_offset_r;

  `FBPA_ASSERT(a_one_port_op, clk, rst_n, !(mem_req.we && mem_req.re))
  `FBPA_ASSERT(a_pop_has_result, clk, rst_n, (state_r != fbpa_pkg::ST_POP) || out_valid_r)
  `FBPA_ASSERT_NEXT(a_pop_one_cycle, clk, rst_n, state_r == fbpa_pkg::ST_POP,
                    state_r == fbpa_pkg::ST_IDLE)
  `FBPA_ASSERT_NEXT(a_read_then_pop, clk, rst_n, mem_req.re, state_r == fbpa_pkg::ST_POP)

endmodule

FILE: rtl/fixed_block_pool_allocator_unit.sv
`timescale 1ns / 1ps
// Result: a result word is registered and valid in the cycle after its command word is taken.
// Input: an allocate that leaves chunks on the list holds in_stall high in ST_POP, since the
//   next-chunk table read at the head is registered; other words stall only under out_stall.
// Reset: after rst_n the table is filled with its chained order, one entry per cycle,
//   for all min(POOL_CHUNKS, 1024) entries with in_stall high; cfg writes are taken throughout.
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Hands out and takes back equal-size chunks through a FIFO free list.
// ----------------------------------------------------------------------------

module fixed_block_pool_allocator_unit #(
  parameter int unsigned POOL_CHUNKS = fbpa_pkg::POOL_CHUNKS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fbpa_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [fbpa_pkg::REQ_W-1:0]  in_request_bytes,
  input  logic                        in_pointer_valid,
  input  logic [fbpa_pkg::IDX_W-1:0]  in_free_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fbpa_pkg::STAT_W-1:0] out_status,
  output logic [fbpa_pkg::IDX_W-1:0]  out_chunk_index,
  output logic [fbpa_pkg::OFF_W-1:0]  out_byte_offset
);

  localparam int unsigned MEM_DEPTH =
    (POOL_CHUNKS < fbpa_pkg::MAX_CHUNKS) ? POOL_CHUNKS : fbpa_pkg::MAX_CHUNKS;

  logic [fbpa_pkg::CFG_W-1:0] chunk_bytes_r;
  logic [fbpa_pkg::CFG_W-1:0] chunk_size;
  fbpa_pkg::fbpa_mem_req_t    mem_req;
  logic [fbpa_pkg::IDX_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_bytes_r <= fbpa_pkg::CHUNK_BYTES_RESET;
    end else if (cfg_we) begin
      chunk_bytes_r <= cfg_wdata;
    end
  end

  // clamp to pointer size below and to the largest chunk above
  always_comb begin
    if (chunk_bytes_r < fbpa_pkg::MIN_CHUNK_BYTES) begin
      chunk_size = fbpa_pkg::MIN_CHUNK_BYTES;
    end else if (chunk_bytes_r > fbpa_pkg::MAX_CHUNK_BYTES) begin
      chunk_size = fbpa_pkg::MAX_CHUNK_BYTES;
    end else begin
      chunk_size = chunk_bytes_r;
    end
  end

  fbpa_ctrl #(
    .POOL_CHUNKS (POOL_CHUNKS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_request_bytes (in_request_bytes),
    .in_pointer_valid (in_pointer_valid),
    .in_free_index    (in_free_index),
    .chunk_size       (chunk_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_chunk_index  (out_chunk_index),
    .out_byte_offset  (out_byte_offset),
    .mem_req          (mem_req),
    .mem_rdata        (mem_rdata)
  );

  fbpa_next_mem #(
    .DEPTH (MEM_DEPTH)
  ) u_next_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule
